[rtl/core/spps_pkg.sv]
// Shared types, constants and helper functions of the servo pick-and-place sequencer.
`timescale 1ns / 1ps

package spps_pkg;

   localparam int POS_W  = 10;
   localparam int TICK_W = 11;
   localparam int STEP_W = 8;
   localparam int CH_W   = 2;
   localparam int IDX_W  = 3;

   localparam logic [POS_W-1:0]  HOME_BASE     = 10'd330;
   localparam logic [POS_W-1:0]  HOME_SHOULDER = 10'd150;
   localparam logic [POS_W-1:0]  HOME_ELBOW    = 10'd300;
   localparam logic [POS_W-1:0]  REST_SHOULDER = 10'd150;
   localparam logic [POS_W-1:0]  REST_ELBOW    = 10'd300;
   localparam logic [POS_W-1:0]  POS_MIN       = 10'd150;
   localparam logic [POS_W-1:0]  POS_MAX       = 10'd600;
   localparam logic [POS_W-1:0]  MIRROR        = 10'd750;
   localparam logic [TICK_W-1:0] TICK_MAX      = 11'd2047;
   localparam logic [TICK_W-1:0] WAIT_MAX      = 11'd1278;

   // Register reset values
   localparam logic [STEP_W-1:0] RST_STEP_INTERVAL = 8'd12;
   localparam logic [POS_W-1:0]  RST_GRIP_PAUSE    = 10'd500;
   localparam logic [POS_W-1:0]  RST_BASE_LOW      = 10'd250;
   localparam logic [POS_W-1:0]  RST_BASE_HIGH     = 10'd450;
   localparam logic [POS_W-1:0]  RST_SHOULDER_HIGH = 10'd380;
   localparam logic [POS_W-1:0]  RST_ELBOW_HIGH    = 10'd380;
   localparam logic [POS_W-1:0]  RST_GRIP_OPEN     = 10'd510;
   localparam logic [POS_W-1:0]  RST_GRIP_CLOSE    = 10'd410;

   // Register indexes
   localparam logic [IDX_W-1:0] REG_STEP_INTERVAL = 3'd0;
   localparam logic [IDX_W-1:0] REG_GRIP_PAUSE    = 3'd1;
   localparam logic [IDX_W-1:0] REG_BASE_LOW      = 3'd2;
   localparam logic [IDX_W-1:0] REG_BASE_HIGH     = 3'd3;
   localparam logic [IDX_W-1:0] REG_SHOULDER_HIGH = 3'd4;
   localparam logic [IDX_W-1:0] REG_ELBOW_HIGH    = 3'd5;
   localparam logic [IDX_W-1:0] REG_GRIP_OPEN     = 3'd6;
   localparam logic [IDX_W-1:0] REG_GRIP_CLOSE    = 3'd7;

   // Servo channels
   localparam logic [CH_W-1:0] CH_BASE     = 2'd0;
   localparam logic [CH_W-1:0] CH_SHOULDER = 2'd1;
   localparam logic [CH_W-1:0] CH_ELBOW    = 2'd2;
   localparam logic [CH_W-1:0] CH_GRIPPER  = 2'd3;

   typedef enum logic [7:0] {
      PH_BASE_DOWN     = 8'b0000_0001,
      PH_SHOULDER_UP   = 8'b0000_0010,
      PH_ELBOW_UP      = 8'b0000_0100,
      PH_GRIP_OPEN     = 8'b0000_1000,
      PH_GRIP_CLOSE    = 8'b0001_0000,
      PH_ELBOW_DOWN    = 8'b0010_0000,
      PH_SHOULDER_DOWN = 8'b0100_0000,
      PH_BASE_UP       = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [STEP_W-1:0] step_interval;
      logic [POS_W-1:0]  grip_pause;
      logic [POS_W-1:0]  base_low;
      logic [POS_W-1:0]  base_high;
      logic [POS_W-1:0]  shoulder_high;
      logic [POS_W-1:0]  elbow_high;
      logic [POS_W-1:0]  grip_open;
      logic [POS_W-1:0]  grip_close;
   } cfg_type;

   typedef struct packed {
      logic             emit;
      logic             servo_write;
      logic [CH_W-1:0]  channel;
      logic [POS_W-1:0] pulse_count;
      logic [POS_W-1:0] position;
      logic             cycle_done;
   } result_type;

   function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] val);
      logic [POS_W-1:0] p;
      if (val < POS_MIN) begin
         p = POS_MIN;
      end else if (val > POS_MAX) begin
         p = POS_MAX;
      end else begin
         p = val;
      end
      return p;
   endfunction

endpackage

[rtl/core/spps_csr.sv]
// Configuration register file of the servo pick-and-place sequencer.
`timescale 1ns / 1ps

module spps_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [spps_pkg::IDX_W-1:0]  csr_index,
   input  logic [spps_pkg::POS_W-1:0]  csr_wdata,
   output spps_pkg::cfg_type           cfg
);

   spps_pkg::cfg_type cfg_ff;
   spps_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            spps_pkg::REG_STEP_INTERVAL:
               cfg_in.step_interval = csr_wdata[spps_pkg::STEP_W-1:0];
            spps_pkg::REG_GRIP_PAUSE:    cfg_in.grip_pause    = csr_wdata;
            spps_pkg::REG_BASE_LOW:      cfg_in.base_low      = csr_wdata;
            spps_pkg::REG_BASE_HIGH:     cfg_in.base_high     = csr_wdata;
            spps_pkg::REG_SHOULDER_HIGH: cfg_in.shoulder_high = csr_wdata;
            spps_pkg::REG_ELBOW_HIGH:    cfg_in.elbow_high    = csr_wdata;
            spps_pkg::REG_GRIP_OPEN:     cfg_in.grip_open     = csr_wdata;
            spps_pkg::REG_GRIP_CLOSE:    cfg_in.grip_close    = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_interval <= spps_pkg::RST_STEP_INTERVAL;
         cfg_ff.grip_pause    <= spps_pkg::RST_GRIP_PAUSE;
         cfg_ff.base_low      <= spps_pkg::RST_BASE_LOW;
         cfg_ff.base_high     <= spps_pkg::RST_BASE_HIGH;
         cfg_ff.shoulder_high <= spps_pkg::RST_SHOULDER_HIGH;
         cfg_ff.elbow_high    <= spps_pkg::RST_ELBOW_HIGH;
         cfg_ff.grip_open     <= spps_pkg::RST_GRIP_OPEN;
         cfg_ff.grip_close    <= spps_pkg::RST_GRIP_CLOSE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/core/spps_engine.sv]
// Sequencer state and one-tick step logic: tick timer, phase machine, clamp and mirror.
`timescale 1ns / 1ps

module spps_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic                 restart,
   input  logic                 driver_ready,
   input  spps_pkg::cfg_type    cfg,
   output spps_pkg::result_type res
);

   spps_pkg::phase_type               phase_ff, phase_in, phase_cur;
   logic [spps_pkg::POS_W-1:0]        base_pos_ff, base_pos_in, base_cur;
   logic [spps_pkg::POS_W-1:0]        shoulder_pos_ff, shoulder_pos_in, shoulder_cur;
   logic [spps_pkg::POS_W-1:0]        elbow_pos_ff, elbow_pos_in, elbow_cur;
   logic [spps_pkg::TICK_W-1:0]       tick_count_ff, tick_count_in, tick_inc;
   logic [spps_pkg::TICK_W-1:0]       wait_target_ff, wait_target_in;
   logic                              due;
   logic                              wr;
   logic                              status;
   logic [spps_pkg::CH_W-1:0]         wr_ch;
   logic [spps_pkg::POS_W-1:0]        wr_val;
   logic [spps_pkg::POS_W-1:0]        clamped;

   always_comb begin
      // restart reloads the home pose before this tick is evaluated
      if (restart) begin
         phase_cur    = spps_pkg::PH_BASE_DOWN;
         base_cur     = spps_pkg::HOME_BASE;
         shoulder_cur = spps_pkg::HOME_SHOULDER;
         elbow_cur    = spps_pkg::HOME_ELBOW;
      end else begin
         phase_cur    = phase_ff;
         base_cur     = base_pos_ff;
         shoulder_cur = shoulder_pos_ff;
         elbow_cur    = elbow_pos_ff;
      end

      tick_inc = (tick_count_ff == spps_pkg::TICK_MAX) ? tick_count_ff
                                                       : tick_count_ff + 1'b1;
      due = (tick_inc >= wait_target_ff);

      phase_in        = phase_cur;
      base_pos_in     = base_cur;
      shoulder_pos_in = shoulder_cur;
      elbow_pos_in    = elbow_cur;
      tick_count_in   = tick_inc;
      wait_target_in  = wait_target_ff;
      wr              = 1'b0;
      status          = 1'b0;
      wr_ch           = spps_pkg::CH_BASE;
      wr_val          = base_cur;

      if (due) begin
         tick_count_in  = '0;
         wait_target_in = {{(spps_pkg::TICK_W-spps_pkg::STEP_W){1'b0}}, cfg.step_interval};
         unique case (phase_cur)
            spps_pkg::PH_BASE_DOWN: begin
               if (base_cur > cfg.base_low) begin
                  base_pos_in = base_cur - 1'b1;
                  wr     = 1'b1;
                  wr_ch  = spps_pkg::CH_BASE;
                  wr_val = base_pos_in;
               end else begin
                  phase_in = spps_pkg::PH_SHOULDER_UP;
               end
            end
            spps_pkg::PH_SHOULDER_UP: begin
               if (shoulder_cur < cfg.shoulder_high) begin
                  shoulder_pos_in = shoulder_cur + 1'b1;
                  wr     = 1'b1;
                  wr_ch  = spps_pkg::CH_SHOULDER;
                  wr_val = shoulder_pos_in;
               end else begin
                  phase_in = spps_pkg::PH_ELBOW_UP;
               end
            end
            spps_pkg::PH_ELBOW_UP: begin
               if (elbow_cur < cfg.elbow_high) begin
                  elbow_pos_in = elbow_cur + 1'b1;
                  wr     = 1'b1;
                  wr_ch  = spps_pkg::CH_ELBOW;
                  wr_val = elbow_pos_in;
               end else begin
                  phase_in = spps_pkg::PH_GRIP_OPEN;
               end
            end
            spps_pkg::PH_GRIP_OPEN: begin
               wr       = 1'b1;
               wr_ch    = spps_pkg::CH_GRIPPER;
               wr_val   = cfg.grip_open;
               phase_in = spps_pkg::PH_GRIP_CLOSE;
               // hold the open gripper for the extra pause
               wait_target_in = {{(spps_pkg::TICK_W-spps_pkg::STEP_W){1'b0}}, cfg.step_interval}
                              + {{(spps_pkg::TICK_W-spps_pkg::POS_W){1'b0}}, cfg.grip_pause};
            end
            spps_pkg::PH_GRIP_CLOSE: begin
               wr       = 1'b1;
               wr_ch    = spps_pkg::CH_GRIPPER;
               wr_val   = cfg.grip_close;
               phase_in = spps_pkg::PH_ELBOW_DOWN;
            end
            spps_pkg::PH_ELBOW_DOWN: begin
               if (elbow_cur > spps_pkg::REST_ELBOW) begin
                  elbow_pos_in = elbow_cur - 1'b1;
                  wr     = 1'b1;
                  wr_ch  = spps_pkg::CH_ELBOW;
                  wr_val = elbow_pos_in;
               end else begin
                  phase_in = spps_pkg::PH_SHOULDER_DOWN;
               end
            end
            spps_pkg::PH_SHOULDER_DOWN: begin
               if (shoulder_cur > spps_pkg::REST_SHOULDER) begin
                  shoulder_pos_in = shoulder_cur - 1'b1;
                  wr     = 1'b1;
                  wr_ch  = spps_pkg::CH_SHOULDER;
                  wr_val = shoulder_pos_in;
               end else begin
                  phase_in = spps_pkg::PH_BASE_UP;
               end
            end
            spps_pkg::PH_BASE_UP: begin
               if (base_cur < cfg.base_high) begin
                  base_pos_in = base_cur + 1'b1;
                  wr     = 1'b1;
                  wr_ch  = spps_pkg::CH_BASE;
                  wr_val = base_pos_in;
               end else begin
                  // cycle complete: back to home and publish status
                  phase_in        = spps_pkg::PH_BASE_DOWN;
                  base_pos_in     = spps_pkg::HOME_BASE;
                  shoulder_pos_in = spps_pkg::HOME_SHOULDER;
                  elbow_pos_in    = spps_pkg::HOME_ELBOW;
                  status          = 1'b1;
               end
            end
            default: begin
               phase_in = spps_pkg::PH_BASE_DOWN;
            end
         endcase
      end

      clamped = spps_pkg::clamp_pos(wr_val);

      res = '0;
      if (status) begin
         res.emit       = 1'b1;
         res.cycle_done = 1'b1;
      end else if (wr && driver_ready) begin
         res.emit        = 1'b1;
         res.servo_write = 1'b1;
         res.channel     = wr_ch;
         res.position    = clamped;
         res.pulse_count = (wr_ch == spps_pkg::CH_SHOULDER || wr_ch == spps_pkg::CH_ELBOW)
                         ? spps_pkg::MIRROR - clamped : clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= spps_pkg::PH_BASE_DOWN;
         base_pos_ff     <= spps_pkg::HOME_BASE;
         shoulder_pos_ff <= spps_pkg::HOME_SHOULDER;
         elbow_pos_ff    <= spps_pkg::HOME_ELBOW;
         tick_count_ff   <= '0;
         wait_target_ff  <= {{(spps_pkg::TICK_W-spps_pkg::STEP_W){1'b0}},
                             spps_pkg::RST_STEP_INTERVAL};
      end else if (step_en) begin
         phase_ff        <= phase_in;
         base_pos_ff     <= base_pos_in;
         shoulder_pos_ff <= shoulder_pos_in;
         elbow_pos_ff    <= elbow_pos_in;
         tick_count_ff   <= tick_count_in;
         wait_target_ff  <= wait_target_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_emit_only_on_step: assert property (@(posedge clock) disable iff (reset)
      res.emit |-> due)
      else $error("result raised on a tick that takes no step");

   a_tick_restarts: assert property (@(posedge clock) disable iff (reset)
      step_en && due |=> tick_count_ff == '0)
      else $error("tick counter not cleared after a step");

   a_wait_bounded: assert property (@(posedge clock) disable iff (reset)
      wait_target_ff <= spps_pkg::WAIT_MAX)
      else $error("wait target beyond interval plus pause");

   a_home_after_cycle: assert property (@(posedge clock) disable iff (reset)
      step_en && res.cycle_done |=> phase_ff == spps_pkg::PH_BASE_DOWN
                                    && base_pos_ff == spps_pkg::HOME_BASE
                                    && elbow_pos_ff == spps_pkg::HOME_ELBOW)
      else $error("home pose not reloaded at end of cycle");
`endif

endmodule

[rtl/core/servo_pick_place_sequencer_unit.sv]
// Top level of the servo pick-and-place sequencer: input and result registers around the engine.
`timescale 1ns / 1ps

// A tick is held in the input register; a result it emits is loaded into the result register.
// Throughput: one tick per cycle while rsp_ready is high, as the input register then moves every
// cycle; the result register loads on each emit, and a waiting result still lets one tick be held.
// Reset (synchronous, active high) clears all handshake state, the registers to their
// defaults and the sequencer to its first phase with the home pose and a cleared tick counter.
module servo_pick_place_sequencer_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_restart,
   input  logic                        req_driver_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_servo_write,
   output logic [spps_pkg::CH_W-1:0]   rsp_channel,
   output logic [spps_pkg::POS_W-1:0]  rsp_pulse_count,
   output logic [spps_pkg::POS_W-1:0]  rsp_position,
   output logic                        rsp_cycle_done,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [spps_pkg::IDX_W-1:0]  csr_index,
   input  logic [spps_pkg::POS_W-1:0]  csr_wdata
);

   spps_pkg::cfg_type    cfg;
   spps_pkg::result_type res;

   logic in_valid_ff, in_valid_in;
   logic in_restart_ff;
   logic in_driver_ready_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_servo_write_ff;
   logic [spps_pkg::CH_W-1:0]  rsp_channel_ff;
   logic [spps_pkg::POS_W-1:0] rsp_pulse_count_ff;
   logic [spps_pkg::POS_W-1:0] rsp_position_ff;
   logic rsp_cycle_done_ff;
   logic req_xfer;
   logic fire;
   logic load_rsp;

   spps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   spps_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .step_en      (fire),
      .restart      (in_restart_ff),
      .driver_ready (in_driver_ready_ff),
      .cfg          (cfg),
      .res          (res)
   );

   // advance the held tick whenever the result register is free or being drained
   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign req_xfer  = req_valid && req_ready;
   assign load_rsp  = fire && res.emit;

   assign in_valid_in  = req_xfer ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_restart_ff      <= req_restart;
         in_driver_ready_ff <= req_driver_ready;
      end
      if (load_rsp) begin
         rsp_servo_write_ff <= res.servo_write;
         rsp_channel_ff     <= res.channel;
         rsp_pulse_count_ff <= res.pulse_count;
         rsp_position_ff    <= res.position;
         rsp_cycle_done_ff  <= res.cycle_done;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_servo_write = rsp_servo_write_ff;
   assign rsp_channel     = rsp_channel_ff;
   assign rsp_pulse_count = rsp_pulse_count_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_cycle_done  = rsp_cycle_done_ff;

endmodule
